@@ rtl/sfmnh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmnh_pkg: shared types and constants for the Slim Fly minimal next hop
// Item layouts, configuration register indexes, route kinds and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfmnh_pkg;

    // Field widths
    localparam int GRID_W     = 5;
    localparam int DIST_W     = 16;
    localparam int DIST_IW    = 4;
    localparam int COORD_W    = 4;
    localparam int TERM_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_ZERO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_ONE   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [GRID_W-1:0] GRID_RESET = 5'd5;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH     = 16;
    localparam int DEF_MAX_TERMINALS = 16;

    // Results per item are capped
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    // Setup: bit-serial reduction of the 4x4 product and the coordinates
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SETUP_STEPS = PROD_W;
    localparam int STEP_W      = 3;

    // Route kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_EJECT  = 2'd0;  // already at destination
    localparam kind_t KIND_COLUMN = 2'd1;  // same subgraph, same column
    localparam kind_t KIND_SAME   = 2'd2;  // same subgraph, other column
    localparam kind_t KIND_CROSS  = 2'd3;  // other subgraph

    typedef struct packed {
        logic               src_subgraph;
        logic [COORD_W-1:0] src_column;
        logic [COORD_W-1:0] src_row;
        logic [TERM_W-1:0]  dst_terminal;
        logic               dst_subgraph;
        logic [COORD_W-1:0] dst_column;
        logic [COORD_W-1:0] dst_row;
    } req_t;

    typedef struct packed {
        logic               eject;
        logic [TERM_W-1:0]  terminal_port;
        logic               hop_subgraph;
        logic [COORD_W-1:0] hop_column;
        logic [COORD_W-1:0] hop_row;
        logic               last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture request, clear lanes
        logic setup;       // one reduction step on every lane
        logic prep;        // clear scan indexes, seed row offsets
        logic adv;         // current scan point consumed
        logic inc_i;
        logic inc_j;
        logic wrap_j;      // j back to zero, next i
        logic next_phase;  // second row sweep of the cross case
        logic flush;       // move pending candidate out marked last
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  single;     // only one scan point
        logic  i_last;
        logic  j_last;
        logic  phase;
        logic  hold;       // hit found but no room downstream
        logic  pend_valid;
        logic  out_free;
    } status_t;

endpackage

@@ rtl/sfmnh_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmnh_datapath: configuration, residue lanes, candidate test and output
// Holds the request, reduces coordinates and the column product modulo q
// bit-serially, tests one scan point per cycle unless held, keeps one pending
// candidate ahead of the output register so the final one can carry last.
// ----------------------------------------------------------------------------
module sfmnh_datapath
    import sfmnh_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_TERMINALS = DEF_MAX_TERMINALS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  req_t                  req_data,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output rsp_t                  rsp_data
);

    localparam int QW        = $clog2(MAX_WIDTH + 1);
    localparam int RW        = ((QW > COORD_W) ? QW : COORD_W) + 1;
    localparam int NUM_LANES = 5;
    localparam int LANE_SC   = 0;
    localparam int LANE_SR   = 1;
    localparam int LANE_DC   = 2;
    localparam int LANE_DR   = 3;
    localparam int LANE_P    = 4;

    // (a + b) mod m for a, b already below m
    function automatic logic [QW-1:0] add_mod(input logic [QW-1:0] a,
                                              input logic [QW-1:0] b,
                                              input logic [QW-1:0] m);
        logic [QW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[QW-1:0];
    endfunction

    // One restoring step: shift in a bit, subtract m if it fits
    function automatic logic [QW-1:0] mod_step(input logic [QW-1:0] r,
                                               input logic          b,
                                               input logic [QW-1:0] m);
        logic [QW:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[QW-1:0];
    endfunction

    // Rows linked when their distance has its bit set
    function automatic logic row_link(input logic [DIST_W-1:0] set,
                                      input logic [RW-1:0]     a,
                                      input logic [RW-1:0]     b);
        logic [RW-1:0] d;
        logic          res;
        d = (a > b) ? (a - b) : (b - a);
        if (d >= RW'(DIST_W))
        begin
            res = 1'b0;
        end
        else
        begin
            res = set[d[DIST_IW-1:0]];
        end
        return res;
    endfunction

    // Configuration
    logic [GRID_W-1:0] grid_width_reg;
    logic [DIST_W-1:0] dist_zero_reg;
    logic [DIST_W-1:0] dist_one_reg;

    // Request and residues
    req_t              req_reg;
    logic [PROD_W-1:0] lane_sh_reg  [NUM_LANES];
    logic [QW-1:0]     lane_rem_reg [NUM_LANES];

    // Scan position and running offsets
    logic [QW-1:0]     i_reg;
    logic [QW-1:0]     j_reg;
    logic              phase_reg;
    logic [QW-1:0]     u_reg;
    logic [QW-1:0]     v_reg;

    // Pending candidate, output register
    rsp_t              pend_reg;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    rsp_t              out_data_reg;
    rsp_t              out_data_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_load;

    logic [QW-1:0]     q;
    kind_t             kind;
    logic              direct;
    logic              hit;
    logic              hit_eff;
    logic              out_free;
    logic              hold;
    rsp_t              cand;
    logic [DIST_W-1:0] set_src;
    logic [DIST_W-1:0] set_dst;
    logic [RW-1:0]     sr_x;
    logic [RW-1:0]     dr_x;
    logic [RW-1:0]     i_x;
    logic [QW-1:0]     t_srm;
    logic [QW-1:0]     t_drm;
    logic [QW-1:0]     t_i;
    logic [TERM_W-1:0] term_sat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_RESET;
            dist_zero_reg  <= '0;
            dist_one_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH: grid_width_reg <= cfg_data[GRID_W-1:0];
                CFG_DIST_ZERO:  dist_zero_reg  <= cfg_data[DIST_W-1:0];
                CFG_DIST_ONE:   dist_one_reg   <= cfg_data[DIST_W-1:0];
                default:        ;
            endcase
        end
    end

    // Modulus clamped to [2, MAX_WIDTH]
    always_comb
    begin
        if (grid_width_reg < GRID_W'(2))
        begin
            q = QW'(2);
        end
        else if (int'(grid_width_reg) > MAX_WIDTH)
        begin
            q = QW'(MAX_WIDTH);
        end
        else
        begin
            q = QW'(grid_width_reg);
        end
    end

    // Request capture, residue lanes, scan indexes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg               <= req_data;
            lane_sh_reg[LANE_SC]  <= PROD_W'(req_data.src_column);
            lane_sh_reg[LANE_SR]  <= PROD_W'(req_data.src_row);
            lane_sh_reg[LANE_DC]  <= PROD_W'(req_data.dst_column);
            lane_sh_reg[LANE_DR]  <= PROD_W'(req_data.dst_row);
            lane_sh_reg[LANE_P]   <= PROD_W'(req_data.src_column)
                                     * PROD_W'(req_data.dst_column);
            for (int k = 0; k < NUM_LANES; k++)
            begin
                lane_rem_reg[k] <= '0;
            end
        end
        else if (cmd.setup)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                lane_rem_reg[k] <= mod_step(lane_rem_reg[k],
                                            lane_sh_reg[k][PROD_W-1], q);
                lane_sh_reg[k]  <= lane_sh_reg[k] << 1;
            end
        end

        if (cmd.prep)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            phase_reg <= 1'b0;
            u_reg     <= req_reg.src_subgraph ? lane_rem_reg[LANE_SR] : '0;
            v_reg     <= req_reg.src_subgraph ? lane_rem_reg[LANE_DR] : '0;
        end
        else if (cmd.inc_j)
        begin
            j_reg <= j_reg + QW'(1);
        end
        else if (cmd.wrap_j)
        begin
            j_reg <= '0;
            i_reg <= i_reg + QW'(1);
            u_reg <= add_mod(u_reg, lane_rem_reg[LANE_SC], q);
            v_reg <= add_mod(v_reg, lane_rem_reg[LANE_DC], q);
        end
        else if (cmd.inc_i)
        begin
            i_reg <= i_reg + QW'(1);
        end
        else if (cmd.next_phase)
        begin
            i_reg     <= '0;
            phase_reg <= 1'b1;
        end
    end

    // Route kind and shared terms
    always_comb
    begin
        if (req_reg.src_subgraph == req_reg.dst_subgraph &&
            req_reg.src_column == req_reg.dst_column &&
            req_reg.src_row == req_reg.dst_row)
        begin
            kind = KIND_EJECT;
        end
        else if (req_reg.src_subgraph == req_reg.dst_subgraph &&
                 req_reg.src_column == req_reg.dst_column)
        begin
            kind = KIND_COLUMN;
        end
        else if (req_reg.src_subgraph == req_reg.dst_subgraph)
        begin
            kind = KIND_SAME;
        end
        else
        begin
            kind = KIND_CROSS;
        end
    end

    assign set_src = req_reg.src_subgraph ? dist_one_reg : dist_zero_reg;
    assign set_dst = req_reg.dst_subgraph ? dist_one_reg : dist_zero_reg;
    assign sr_x    = RW'(req_reg.src_row);
    assign dr_x    = RW'(req_reg.dst_row);
    assign i_x     = RW'(i_reg);
    assign t_srm   = add_mod(lane_rem_reg[LANE_P], lane_rem_reg[LANE_SR], q);
    assign t_drm   = add_mod(lane_rem_reg[LANE_P], lane_rem_reg[LANE_DR], q);
    assign t_i     = add_mod(lane_rem_reg[LANE_P], i_reg, q);
    assign term_sat = (int'(req_reg.dst_terminal) > MAX_TERMINALS - 1)
                      ? TERM_W'(MAX_TERMINALS - 1) : req_reg.dst_terminal;

    // Direct link to the destination
    always_comb
    begin
        case (kind)
            KIND_COLUMN: direct = row_link(set_src, sr_x, dr_x);
            KIND_CROSS:  direct = req_reg.src_subgraph ? (dr_x == RW'(t_srm))
                                                       : (sr_x == RW'(t_drm));
            default:     direct = 1'b0;
        endcase
    end

    // Candidate at the current scan point
    always_comb
    begin
        cand.eject         = 1'b0;
        cand.terminal_port = '0;
        cand.hop_subgraph  = req_reg.dst_subgraph;
        cand.hop_column    = req_reg.dst_column;
        cand.hop_row       = req_reg.dst_row;
        cand.last          = 1'b0;
        hit                = 1'b0;
        case (kind)
            KIND_EJECT:
            begin
                cand.eject         = 1'b1;
                cand.terminal_port = term_sat;
                hit                = 1'b1;
            end
            KIND_COLUMN:
            begin
                if (direct)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    cand.hop_subgraph = req_reg.src_subgraph;
                    cand.hop_column   = req_reg.src_column;
                    cand.hop_row      = COORD_W'(i_reg);
                    hit = row_link(set_src, sr_x, i_x) && row_link(set_src, i_x, dr_x);
                end
            end
            KIND_SAME:
            begin
                cand.hop_subgraph = ~req_reg.src_subgraph;
                cand.hop_column   = COORD_W'(i_reg);
                cand.hop_row      = COORD_W'(j_reg);
                if (req_reg.src_subgraph)
                begin
                    hit = (j_reg == u_reg) && (j_reg == v_reg);
                end
                else
                begin
                    hit = (sr_x == RW'(add_mod(u_reg, j_reg, q))) &&
                          (dr_x == RW'(add_mod(v_reg, j_reg, q)));
                end
            end
            KIND_CROSS:
            begin
                if (direct)
                begin
                    hit = 1'b1;
                end
                else if (!phase_reg)
                begin
                    // rows of the destination column
                    cand.hop_row = COORD_W'(i_reg);
                    hit = (req_reg.src_subgraph ? (i_reg == t_srm)
                                                : (sr_x == RW'(t_i))) &&
                          row_link(set_dst, dr_x, i_x);
                end
                else
                begin
                    // rows of the source column
                    cand.hop_subgraph = req_reg.src_subgraph;
                    cand.hop_column   = req_reg.src_column;
                    cand.hop_row      = COORD_W'(i_reg);
                    hit = row_link(set_src, sr_x, i_x) &&
                          (req_reg.src_subgraph ? (dr_x == RW'(t_i))
                                                : (i_reg == t_drm));
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign hit_eff  = hit && (count_reg < CNT_W'(MAX_RESULTS));
    assign out_free = !out_valid_reg || !rsp_stall;
    assign hold     = hit_eff && pend_valid_reg && !out_free;
    assign out_load = cmd.adv && hit_eff && pend_valid_reg;

    // Pending slot and output register, next values
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_data_next   = pend_reg;
        if (cmd.load)
        begin
            pend_valid_next = 1'b0;
            count_next      = '0;
        end
        if (cmd.adv && hit_eff)
        begin
            pend_valid_next = 1'b1;
            count_next      = count_reg + CNT_W'(1);
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.flush)
        begin
            pend_valid_next    = 1'b0;
            out_valid_next     = 1'b1;
            out_data_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.adv && hit_eff)
        begin
            pend_reg <= cand;
        end
        if (out_load || cmd.flush)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // Status to the controller
    assign status.kind       = kind;
    assign status.single     = (kind == KIND_EJECT) || direct;
    assign status.i_last     = (i_reg == q - QW'(1));
    assign status.j_last     = (j_reg == q - QW'(1));
    assign status.phase      = phase_reg;
    assign status.hold       = hold;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

`ifndef SYNTH
    // result cap is never passed
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond cap");

    // flush only with a pending candidate and room downstream
    a_flush_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> pend_valid_reg && out_free)
        else $error("flush without pending item or room");

    // a held scan point must not be consumed
    a_no_adv_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.adv |-> !hold)
        else $error("scan advanced while held");

    // running offsets stay reduced
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.adv && kind == KIND_SAME) |-> (u_reg < q) && (v_reg < q))
        else $error("row offset not reduced");

    // output only ever fed from the pending slot
    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pend_valid_reg))
        else $error("output loaded without pending item");
`endif

endmodule

@@ rtl/sfmnh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmnh_ctrl: request sequencer
// Accepts an item, runs the residue setup, walks the scan points of the
// route kind and flushes the final candidate.
// ----------------------------------------------------------------------------
module sfmnh_ctrl
    import sfmnh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SETUP_STEPS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!status.hold)
                begin
                    cmd.adv = 1'b1;
                    if (status.single)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        case (status.kind)
                            KIND_SAME:
                            begin
                                if (!status.j_last)
                                begin
                                    cmd.inc_j = 1'b1;
                                end
                                else if (!status.i_last)
                                begin
                                    cmd.wrap_j = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                            KIND_CROSS:
                            begin
                                if (!status.i_last)
                                begin
                                    cmd.inc_i = 1'b1;
                                end
                                else if (!status.phase)
                                begin
                                    cmd.next_phase = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                            default:
                            begin
                                if (!status.i_last)
                                begin
                                    cmd.inc_i = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/slim_fly_min_next_hop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slim_fly_min_next_hop: minimal next hops on a two-subgraph MMS graph
// Lists every neighbour on a minimal path to the destination, or one eject
// item when the current router is the destination.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  req      | req_valid / req_stall  | req_data  (current and destination)
//  rsp      | rsp_valid / rsp_stall  | rsp_data  (next hop or eject, last)
//  cfg      | cfg_wr_en              | cfg_index, cfg_data
//
//  One item at a time: accept, residue setup, prep, scan, flush.
//  Scan points: 1 for eject or a direct link, q for a same-column search,
//  2q for a cross-subgraph search, q*q for same subgraph, other column;
//  one point tested per cycle while the scan is not held.
//  rsp_stall holds the scan only when a new hit finds the pending slot and
//  the output register both full, and holds the flush until the output
//  register is free. Reset clears control state and configuration only.
//
module slim_fly_min_next_hop
    import sfmnh_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_TERMINALS = DEF_MAX_TERMINALS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data
);

    cmd_t    cmd;
    status_t status;

    sfmnh_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sfmnh_datapath
    #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_TERMINALS (MAX_TERMINALS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule
